FILE: rtl/core/uart_rb_pkg.sv
package uart_rb_pkg;

   // item kinds
   localparam logic [1:0] KIND_READ   = 2'd0;
   localparam logic [1:0] KIND_WRITE  = 2'd1;
   localparam logic [1:0] KIND_RXBYTE = 2'd2;
   localparam logic [1:0] KIND_BREAK  = 2'd3;

   // register byte offsets
   localparam logic [5:0] OFF_MODE    = 6'h00;
   localparam logic [5:0] OFF_STATUS  = 6'h04;
   localparam logic [5:0] OFF_CMD     = 6'h08;
   localparam logic [5:0] OFF_FIFO    = 6'h0c;
   localparam logic [5:0] OFF_INT     = 6'h14;
   localparam logic [5:0] OFF_BAUD_HI = 6'h18;
   localparam logic [5:0] OFF_BAUD_LO = 6'h1c;

   // command byte fields
   localparam logic [2:0] MISC_PTR_RESET = 3'd1;
   localparam logic [2:0] MISC_RX_RESET  = 3'd2;
   localparam logic [2:0] MISC_TX_RESET  = 3'd3;
   localparam logic [2:0] MISC_CLR_DB    = 3'd5;
   localparam logic [1:0] EN_CMD_ENABLE  = 2'd1;
   localparam logic [1:0] EN_CMD_DISABLE = 2'd2;

   // interrupt status bit positions
   localparam int IS_TX = 0;
   localparam int IS_RX = 1;
   localparam int IS_DB = 2;

   // mode register 0 bit that selects full instead of ready for rx interrupt
   localparam int MODE_RXINT_FFULL = 6;

   // csr register indexes (paddr bit 2)
   localparam logic CSR_BAUD_HI = 1'b0;
   localparam logic CSR_BAUD_LO = 1'b1;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [7:0] data;
   } rxf_op_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [2:0] rx_space;
   } rsp_type;

endpackage

FILE: rtl/core/uart_rb_rxfifo.sv
module uart_rb_rxfifo #(
   parameter int RX_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  uart_rb_pkg::rxf_op_type         op,
   output logic [$clog2(RX_DEPTH+1)-1:0]   count,
   output logic [$clog2(RX_DEPTH+1)-1:0]   count_next,
   output logic [7:0]                      head
);

   localparam int CW = $clog2(RX_DEPTH + 1);

   logic [7:0]    mem_ff [RX_DEPTH];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] wsel;
   logic          full;
   logic          do_pop;

   assign full   = (count_ff == CW'(RX_DEPTH));
   assign wsel   = full ? CW'(RX_DEPTH - 1) : count_ff;
   assign do_pop = op.pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (op.clear) begin
         count_in = '0;
      end else if (op.push) begin
         // overflow overwrites the newest entry, count stays at depth
         count_in = full ? count_ff : count_ff + CW'(1);
      end else if (do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   for (genvar i = 0; i < RX_DEPTH; i++) begin : g_entry
      if (i < RX_DEPTH - 1) begin : g_shift
         always_ff @(posedge clock) begin
            if (op.push && wsel == CW'(i)) begin
               mem_ff[i] <= op.data;
            end else if (do_pop) begin
               mem_ff[i] <= mem_ff[i+1];
            end
         end
      end else begin : g_last
         always_ff @(posedge clock) begin
            if (op.push && wsel == CW'(i)) begin
               mem_ff[i] <= op.data;
            end
         end
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;
   assign head       = mem_ff[0];

endmodule

FILE: rtl/core/uart_rb_ctrl.sv
module uart_rb_ctrl #(
   parameter int RX_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  logic [1:0]                      kind,
   input  logic [5:0]                      offset,
   input  logic [7:0]                      write_data,
   input  logic [7:0]                      rx_byte,
   input  logic [7:0]                      baud_high,
   input  logic [7:0]                      baud_low,
   input  logic [$clog2(RX_DEPTH+1)-1:0]   fifo_count,
   input  logic [$clog2(RX_DEPTH+1)-1:0]   fifo_count_next,
   input  logic [7:0]                      fifo_head,
   output uart_rb_pkg::rxf_op_type         fifo_op,
   output uart_rb_pkg::rsp_type            result
);

   localparam int CW = $clog2(RX_DEPTH + 1);
   localparam int SW = (CW > 3) ? CW : 3;

   logic [7:0] mode0_ff, mode0_in;
   logic [7:0] mode1_ff, mode1_in;
   logic       ptr_ff, ptr_in;
   logic       txrdy_ff, txrdy_in;
   logic       txemp_ff, txemp_in;
   logic       tx_on_ff, tx_on_in;
   logic       rx_on_ff, rx_on_in;
   logic [7:0] hold_ff, hold_in;
   logic [2:0] ist_ff, ist_in;
   logic [7:0] mask_ff, mask_in;

   uart_rb_pkg::rxf_op_type op;
   logic       refresh;
   logic       do_try;
   logic       sent;
   logic [7:0] rd;
   logic       rxrdy_cur, ffull_cur;
   logic       rxrdy_n, ffull_n;
   logic [SW-1:0] space;

   // fifo flags follow the fill count
   assign rxrdy_cur = (fifo_count != '0);
   assign ffull_cur = (fifo_count == CW'(RX_DEPTH));
   assign rxrdy_n   = (fifo_count_next != '0);
   assign ffull_n   = (fifo_count_next == CW'(RX_DEPTH));

   always_comb begin
      mode0_in = mode0_ff;
      mode1_in = mode1_ff;
      ptr_in   = ptr_ff;
      txrdy_in = txrdy_ff;
      txemp_in = txemp_ff;
      tx_on_in = tx_on_ff;
      rx_on_in = rx_on_ff;
      hold_in  = hold_ff;
      ist_in   = ist_ff;
      mask_in  = mask_ff;
      op       = '0;
      refresh  = 1'b0;
      do_try   = 1'b0;
      sent     = 1'b0;
      rd       = 8'd0;
      case (kind)
         uart_rb_pkg::KIND_READ: begin
            case (offset)
               uart_rb_pkg::OFF_MODE:    rd = ptr_ff ? mode1_ff : mode0_ff;
               uart_rb_pkg::OFF_STATUS:
                  rd = {4'd0, txemp_ff, txrdy_ff, ffull_cur, rxrdy_cur};
               uart_rb_pkg::OFF_FIFO: begin
                  op.pop = 1'b1;
                  if (rxrdy_cur) begin
                     rd      = fifo_head;
                     refresh = 1'b1;
                  end
               end
               uart_rb_pkg::OFF_INT:     rd = {5'd0, ist_ff};
               uart_rb_pkg::OFF_BAUD_HI: rd = baud_high;
               uart_rb_pkg::OFF_BAUD_LO: rd = baud_low;
               default:                  rd = 8'd0;
            endcase
         end
         uart_rb_pkg::KIND_WRITE: begin
            refresh = 1'b1;
            case (offset)
               uart_rb_pkg::OFF_MODE: begin
                  if (ptr_ff) begin
                     mode1_in = write_data;
                  end else begin
                     mode0_in = write_data;
                  end
                  ptr_in = 1'b1;
               end
               uart_rb_pkg::OFF_CMD: begin
                  case (write_data[6:4])
                     uart_rb_pkg::MISC_PTR_RESET: ptr_in = 1'b0;
                     uart_rb_pkg::MISC_RX_RESET: begin
                        rx_on_in = 1'b0;
                        op.clear = 1'b1;
                     end
                     uart_rb_pkg::MISC_TX_RESET: begin
                        tx_on_in = 1'b0;
                        txemp_in = 1'b1;
                        txrdy_in = 1'b0;
                     end
                     uart_rb_pkg::MISC_CLR_DB: ist_in[uart_rb_pkg::IS_DB] = 1'b0;
                     default: ;
                  endcase
                  case (write_data[3:2])
                     uart_rb_pkg::EN_CMD_ENABLE: begin
                        tx_on_in = 1'b1;
                        do_try   = 1'b1;
                     end
                     uart_rb_pkg::EN_CMD_DISABLE: begin
                        tx_on_in = 1'b0;
                        do_try   = 1'b1;
                     end
                     default: ;
                  endcase
                  case (write_data[1:0])
                     uart_rb_pkg::EN_CMD_ENABLE:  rx_on_in = 1'b1;
                     uart_rb_pkg::EN_CMD_DISABLE: rx_on_in = 1'b0;
                     default: ;
                  endcase
               end
               uart_rb_pkg::OFF_FIFO: begin
                  txemp_in = 1'b0;
                  hold_in  = write_data;
                  do_try   = 1'b1;
               end
               uart_rb_pkg::OFF_INT: mask_in = write_data;
               default: ;
            endcase
         end
         uart_rb_pkg::KIND_RXBYTE: begin
            op.push = 1'b1;
            op.data = rx_byte;
            refresh = 1'b1;
         end
         default: begin
            // line break pushes a zero byte
            ist_in[uart_rb_pkg::IS_DB] = 1'b1;
            op.push = 1'b1;
            op.data = 8'd0;
            refresh = 1'b1;
         end
      endcase

      // transmitter: pending byte goes out once enabled
      if (do_try) begin
         if (tx_on_in && !txemp_in) begin
            sent     = 1'b1;
            txemp_in = 1'b1;
         end
         txrdy_in = tx_on_in;
      end

      if (refresh) begin
         ist_in[uart_rb_pkg::IS_TX] = txrdy_in;
         ist_in[uart_rb_pkg::IS_RX] = mode0_in[uart_rb_pkg::MODE_RXINT_FFULL] ? ffull_n
                                                                              : rxrdy_n;
      end
   end

   assign space = SW'(RX_DEPTH) - SW'(fifo_count_next);

   always_comb begin
      result.read_data = rd;
      result.irq       = |({5'd0, ist_in} & mask_in);
      result.tx_valid  = sent;
      result.tx_byte   = sent ? hold_in : 8'd0;
      result.rx_space  = rx_on_in ? space[2:0] : 3'd0;
   end

   assign fifo_op = fire ? op : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode0_ff <= 8'd0;
         mode1_ff <= 8'd0;
         ptr_ff   <= 1'b0;
         txrdy_ff <= 1'b0;
         txemp_ff <= 1'b1;
         tx_on_ff <= 1'b0;
         rx_on_ff <= 1'b0;
         ist_ff   <= 3'd0;
         mask_ff  <= 8'd0;
      end else if (fire) begin
         mode0_ff <= mode0_in;
         mode1_ff <= mode1_in;
         ptr_ff   <= ptr_in;
         txrdy_ff <= txrdy_in;
         txemp_ff <= txemp_in;
         tx_on_ff <= tx_on_in;
         rx_on_ff <= rx_on_in;
         ist_ff   <= ist_in;
         mask_ff  <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         hold_ff <= hold_in;
      end
   end

endmodule

FILE: rtl/core/uart_register_block_with_rx_fifo_unit.sv
// register model of one uart channel with a small receive fifo
// req channel: one item per accept, kind selects bus read, bus write,
//   received byte or line break; offset, write_data and rx_byte carry its operands
// rsp channel: one item per req item, in order: read data, interrupt level,
//   transmitted byte with its valid flag, and free receive entries
// csr port: apb-style, baud generator bytes at 0x0 (high) and 0x4 (low), no wait states
// path: two registers, an input register, then the result register fed by one pass of
//   decode logic; an accepted item moves on when the result register is free or emptied
// throughput: one item per cycle while rsp is not held, set by the single-pass register update
// stall: while rsp is held, the input register still takes one more item;
//   req_ready drops only when both registers are full
// reset: synchronous, clears both registers' valid flags and all control state;
//   status comes up as transmitter empty, fifo empty, everything disabled
// no clearing pass: the fifo entries and the transmit byte need no reset
module uart_register_block_with_rx_fifo_unit #(
   parameter int RX_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_offset,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_irq,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic [2:0]  rsp_rx_space,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW = $clog2(RX_DEPTH + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [1:0] in_kind_ff;
   logic [5:0] in_offset_ff;
   logic [7:0] in_wdata_ff;
   logic [7:0] in_rxbyte_ff;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   uart_rb_pkg::rsp_type  rsp_ff;
   uart_rb_pkg::rsp_type  result;

   // baud generator bytes
   logic [7:0] baud_hi_ff;
   logic [7:0] baud_lo_ff;

   logic                      accept;
   logic                      fire;
   uart_rb_pkg::rxf_op_type   fifo_op;
   logic [CW-1:0]             fifo_count;
   logic [CW-1:0]             fifo_count_next;
   logic [7:0]                fifo_head;
   logic                      csr_wr;

   // an item moves to the result register when that register is free or being emptied
   assign fire      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign accept    = req_valid && req_ready;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         in_kind_ff   <= req_kind;
         in_offset_ff <= req_offset;
         in_wdata_ff  <= req_write_data;
         in_rxbyte_ff <= req_rx_byte;
      end
      if (fire) begin
         rsp_ff <= result;
      end
   end

   // receive fifo: shift-out storage with fill count
   uart_rb_rxfifo #(
      .RX_DEPTH (RX_DEPTH)
   ) u_rxfifo (
      .clock      (clock),
      .reset      (reset),
      .op         (fifo_op),
      .count      (fifo_count),
      .count_next (fifo_count_next),
      .head       (fifo_head)
   );

   // register file, command decode and interrupt logic
   uart_rb_ctrl #(
      .RX_DEPTH (RX_DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .fire            (fire),
      .kind            (in_kind_ff),
      .offset          (in_offset_ff),
      .write_data      (in_wdata_ff),
      .rx_byte         (in_rxbyte_ff),
      .baud_high       (baud_hi_ff),
      .baud_low        (baud_lo_ff),
      .fifo_count      (fifo_count),
      .fifo_count_next (fifo_count_next),
      .fifo_head       (fifo_head),
      .fifo_op         (fifo_op),
      .result          (result)
   );

   // csr port, written in the access phase
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         baud_hi_ff <= 8'd0;
         baud_lo_ff <= 8'd0;
      end else if (csr_wr) begin
         if (csr_paddr[2] == uart_rb_pkg::CSR_BAUD_LO) begin
            baud_lo_ff <= csr_pwdata[7:0];
         end else begin
            baud_hi_ff <= csr_pwdata[7:0];
         end
      end
   end

   assign csr_prdata = {24'd0,
                        (csr_paddr[2] == uart_rb_pkg::CSR_BAUD_HI) ? baud_hi_ff : baud_lo_ff};

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_ff.read_data;
   assign rsp_irq       = rsp_ff.irq;
   assign rsp_tx_valid  = rsp_ff.tx_valid;
   assign rsp_tx_byte   = rsp_ff.tx_byte;
   assign rsp_rx_space  = rsp_ff.rx_space;

   // input side only stalls when the input register holds an item
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff)
      else $error("req_ready low with empty input register");

   // non-read items always return zero read data
   a_read_data_zero: assert property (@(posedge clock) disable iff (reset)
      fire && (in_kind_ff != uart_rb_pkg::KIND_READ) |=> rsp_read_data == 8'd0)
      else $error("read data nonzero for a non-read item");

   // tx byte is zero unless a byte went to the line
   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'd0)
      else $error("tx byte nonzero without tx valid");

   // fifo fill count stays within depth
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count <= CW'(RX_DEPTH))
      else $error("receive fifo count above depth");

endmodule

FILE: test/uart_rb_checker.sv
`timescale 1ns / 100ps
module uart_rb_checker #(
   parameter int RX_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [5:0]  req_offset,
   input  logic [7:0]  req_write_data,
   input  logic [7:0]  req_rx_byte,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_irq,
   input  logic        rsp_tx_valid,
   input  logic [7:0]  rsp_tx_byte,
   input  logic [2:0]  rsp_rx_space,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,

   output int          outstanding,
   output int          fail_count
);

   // status register bits
   localparam logic [7:0] ST_RXRDY = 8'h01;
   localparam logic [7:0] ST_FFULL = 8'h02;
   localparam logic [7:0] ST_TXRDY = 8'h04;
   localparam logic [7:0] ST_TXEMP = 8'h08;

   logic [7:0] baud_hi, baud_lo;
   logic [7:0] mode_r [2];
   logic       mode_ptr;
   logic [7:0] stat, istat, imask;
   logic [7:0] rx_store [RX_DEPTH];
   int         fill;
   logic       tx_en, rx_en;
   logic [7:0] tx_hold_b;
   logic       sent;
   logic [7:0] sent_b;

   uart_rb_pkg::rsp_type expected_rsp_q [$];
   int         mismatches = 0;

   assign fail_count = mismatches;

   function automatic void clear_channel();
      baud_hi = 8'h00;
      baud_lo = 8'h00;
      mode_r[0] = 8'h00;
      mode_r[1] = 8'h00;
      mode_ptr = 1'b0;
      stat = ST_TXEMP;
      istat = 8'h00;
      imask = 8'h00;
      fill = 0;
      tx_en = 1'b0;
      rx_en = 1'b0;
      tx_hold_b = 8'h00;
      sent = 1'b0;
      sent_b = 8'h00;
   endfunction

   function automatic void refresh_irq();
      logic rx_flag;
      rx_flag = mode_r[0][uart_rb_pkg::MODE_RXINT_FFULL] ? |(stat & ST_FFULL)
                                                         : |(stat & ST_RXRDY);
      istat[uart_rb_pkg::IS_TX] = |(stat & ST_TXRDY);
      istat[uart_rb_pkg::IS_RX] = rx_flag;
   endfunction

   function automatic void try_transmit();
      if (tx_en && !(|(stat & ST_TXEMP))) begin
         sent = 1'b1;
         sent_b = tx_hold_b;
         stat = stat | ST_TXEMP;
      end
      if (tx_en) stat = stat | ST_TXRDY;
      else stat = stat & ~ST_TXRDY;
   endfunction

   function automatic void exec_command(logic [7:0] cmd);
      case (cmd[6:4])
         uart_rb_pkg::MISC_PTR_RESET: mode_ptr = 1'b0;
         uart_rb_pkg::MISC_RX_RESET: begin
            rx_en = 1'b0;
            fill = 0;
            stat = stat & ~(ST_RXRDY | ST_FFULL);
         end
         uart_rb_pkg::MISC_TX_RESET: begin
            tx_en = 1'b0;
            stat = (stat | ST_TXEMP) & ~ST_TXRDY;
         end
         uart_rb_pkg::MISC_CLR_DB: istat[uart_rb_pkg::IS_DB] = 1'b0;
         default: ;
      endcase
      case (cmd[3:2])
         uart_rb_pkg::EN_CMD_ENABLE: begin
            tx_en = 1'b1;
            try_transmit();
         end
         uart_rb_pkg::EN_CMD_DISABLE: begin
            tx_en = 1'b0;
            try_transmit();
         end
         default: ;
      endcase
      case (cmd[1:0])
         uart_rb_pkg::EN_CMD_ENABLE: rx_en = 1'b1;
         uart_rb_pkg::EN_CMD_DISABLE: rx_en = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void fifo_push(logic [7:0] b);
      // a full fifo loses its newest entry
      if (fill >= RX_DEPTH) fill = RX_DEPTH - 1;
      rx_store[fill] = b;
      fill++;
      stat = stat | ST_RXRDY;
      if (fill == RX_DEPTH) stat = stat | ST_FFULL;
      refresh_irq();
   endfunction

   function automatic logic [7:0] bus_read(logic [5:0] off);
      logic [7:0] v;
      int i;
      case (off)
         uart_rb_pkg::OFF_MODE: return mode_r[mode_ptr];
         uart_rb_pkg::OFF_STATUS: return stat;
         uart_rb_pkg::OFF_FIFO: begin
            if (fill == 0) return 8'h00;
            v = rx_store[0];
            fill--;
            for (i = 0; i + 1 < RX_DEPTH && i < fill; i++) rx_store[i] = rx_store[i + 1];
            stat = stat & ~ST_FFULL;
            if (fill == 0) stat = stat & ~ST_RXRDY;
            refresh_irq();
            return v;
         end
         uart_rb_pkg::OFF_INT: return istat;
         uart_rb_pkg::OFF_BAUD_HI: return baud_hi;
         uart_rb_pkg::OFF_BAUD_LO: return baud_lo;
         default: return 8'h00;
      endcase
   endfunction

   function automatic void bus_write(logic [5:0] off, logic [7:0] v);
      case (off)
         uart_rb_pkg::OFF_MODE: begin
            mode_r[mode_ptr] = v;
            mode_ptr = 1'b1;
         end
         uart_rb_pkg::OFF_CMD: exec_command(v);
         uart_rb_pkg::OFF_FIFO: begin
            stat = stat & ~ST_TXEMP;
            tx_hold_b = v;
            try_transmit();
         end
         uart_rb_pkg::OFF_INT: imask = v;
         default: ;
      endcase
      refresh_irq();
   endfunction

   function automatic uart_rb_pkg::rsp_type channel_step(logic [1:0] kind, logic [5:0] off,
                                                         logic [7:0] wd, logic [7:0] rb);
      uart_rb_pkg::rsp_type r;
      logic [7:0] rd;
      rd = 8'h00;
      sent = 1'b0;
      sent_b = 8'h00;
      case (kind)
         uart_rb_pkg::KIND_READ: rd = bus_read(off);
         uart_rb_pkg::KIND_WRITE: bus_write(off, wd);
         uart_rb_pkg::KIND_RXBYTE: fifo_push(rb);
         default: begin
            istat[uart_rb_pkg::IS_DB] = 1'b1;
            fifo_push(8'h00);
         end
      endcase
      r.read_data = rd;
      r.irq = |(istat & imask);
      r.tx_valid = sent;
      r.tx_byte = sent ? sent_b : 8'h00;
      r.rx_space = rx_en ? 3'(RX_DEPTH - fill) : 3'd0;
      return r;
   endfunction

   always @(posedge clock) begin
      uart_rb_pkg::rsp_type want, got;
      if (reset) begin
         clear_channel();
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.read_data = rsp_read_data;
            got.irq = rsp_irq;
            got.tx_valid = rsp_tx_valid;
            got.tx_byte = rsp_tx_byte;
            got.rx_space = rsp_rx_space;
            if (expected_rsp_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected item rd=%h irq=%b txv=%b txb=%h space=%0d",
                           $time, got.read_data, got.irq, got.tx_valid, got.tx_byte,
                           got.rx_space);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch exp rd=%h irq=%b txv=%b txb=%h space=%0d, %s",
                              $time, want.read_data, want.irq, want.tx_valid, want.tx_byte,
                              want.rx_space,
                              $sformatf("got rd=%h irq=%b txv=%b txb=%h space=%0d",
                                        got.read_data, got.irq, got.tx_valid, got.tx_byte,
                                        got.rx_space));
               end
            end
         end
         if (req_valid && req_ready)
            expected_rsp_q.push_back(channel_step(req_kind, req_offset, req_write_data,
                                                  req_rx_byte));
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == uart_rb_pkg::CSR_BAUD_LO) baud_lo = csr_pwdata[7:0];
            else baud_hi = csr_pwdata[7:0];
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

FILE: test/tb_uart_register_block_with_rx_fifo_unit.sv
`timescale 1ns / 100ps
module tb_uart_register_block_with_rx_fifo_unit;

   localparam int RX_DEPTH = 4;

   // offsets and command codes the package leaves unnamed
   localparam logic [5:0] OFF_UNUSED = 6'h10;
   localparam logic [5:0] OFF_LAST   = 6'h3f;
   localparam logic [2:0] MISC_NONE  = 3'd0;
   localparam logic [2:0] MISC_RSVD  = 3'd4;
   localparam logic [1:0] EN_NONE    = 2'd0;
   localparam logic [1:0] EN_RSVD    = 2'd3;

   // traffic shapes, one per stretch of the run
   typedef enum int {
      PH_FREE, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH, PH_PRESSURE
   } phase_type;

   // every input has a known value from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic [1:0]  req_kind = uart_rb_pkg::KIND_READ;
   logic [5:0]  req_offset = uart_rb_pkg::OFF_MODE;
   logic [7:0]  req_write_data = 8'h00;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_ready = 1'b0;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;

   logic        req_ready;
   logic        rsp_valid;
   logic [7:0]  rsp_read_data;
   logic        rsp_irq;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic [2:0]  rsp_rx_space;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int          outstanding;
   int          fail_count;
   phase_type   phase = PH_FREE;
   int unsigned hold_cycle = 0;

   uart_register_block_with_rx_fifo_unit #(
      .RX_DEPTH(RX_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_irq(rsp_irq),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_rx_space(rsp_rx_space),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor and comparison live beside the block
   uart_rb_checker #(
      .RX_DEPTH(RX_DEPTH)
   ) u_uart_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_kind(req_kind),
      .req_offset(req_offset),
      .req_write_data(req_write_data),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_read_data(rsp_read_data),
      .rsp_irq(rsp_irq),
      .rsp_tx_valid(rsp_tx_valid),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_rx_space(rsp_rx_space),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_pready(csr_pready),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .outstanding(outstanding),
      .fail_count(fail_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // result side: back-pressure depends on the phase
   always @(posedge clock) begin
      hold_cycle <= hold_cycle + 1;
      case (phase)
         PH_RECV_STALL: rsp_ready <= ($urandom_range(99) >= 56);
         PH_BOTH: rsp_ready <= ($urandom_range(99) >= 20);
         // long hold-offs: ready only in the last quarter of each hold_cycle period, sender keeps pushing
         PH_PRESSURE: rsp_ready <= ((hold_cycle % 64) >= 48);
         default: rsp_ready <= 1'b1;
      endcase
   end

   function automatic logic [7:0] cmd_byte(logic [2:0] misc, logic [1:0] txc, logic [1:0] rxc);
      return {1'b0, misc, txc, rxc};
   endfunction

   // random command with a lean toward the defined codes
   function automatic logic [7:0] random_cmd();
      logic [2:0] misc;
      logic [1:0] txc, rxc;
      int r;
      r = $urandom_range(9);
      case (r)
         0, 1, 2, 3: misc = MISC_NONE;
         4: misc = uart_rb_pkg::MISC_PTR_RESET;
         5: misc = uart_rb_pkg::MISC_RX_RESET;
         6: misc = uart_rb_pkg::MISC_TX_RESET;
         7: misc = uart_rb_pkg::MISC_CLR_DB;
         default: misc = 3'($urandom_range(7));
      endcase
      r = $urandom_range(9);
      txc = (r < 5) ? uart_rb_pkg::EN_CMD_ENABLE :
            (r < 7) ? uart_rb_pkg::EN_CMD_DISABLE : 2'($urandom_range(3));
      r = $urandom_range(9);
      rxc = (r < 5) ? uart_rb_pkg::EN_CMD_ENABLE :
            (r < 7) ? uart_rb_pkg::EN_CMD_DISABLE : 2'($urandom_range(3));
      return {1'($urandom_range(1)), misc, txc, rxc};
   endfunction

   // one item on the request channel; returns at the edge that takes it
   task automatic send_item(input logic [1:0] kind, input logic [5:0] off,
                            input logic [7:0] wd, input logic [7:0] rb);
      int idle_pct;
      idle_pct = (phase == PH_SEND_IDLE) ? 56 : (phase == PH_BOTH) ? 20 : 0;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_offset <= off;
      req_write_data <= wd;
      req_rx_byte <= rb;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_item();
      logic [1:0] kind;
      logic [5:0] off;
      logic [7:0] wd;
      int r, s;
      r = $urandom_range(99);
      s = $urandom_range(9);
      off = 6'($urandom_range(63));
      wd = 8'($urandom_range(255));
      if (r < 34) begin
         kind = uart_rb_pkg::KIND_READ;
         case (s)
            0: off = uart_rb_pkg::OFF_MODE;
            1: off = uart_rb_pkg::OFF_STATUS;
            2, 3, 4: off = uart_rb_pkg::OFF_FIFO;
            5: off = uart_rb_pkg::OFF_INT;
            6: off = uart_rb_pkg::OFF_BAUD_HI;
            7: off = uart_rb_pkg::OFF_BAUD_LO;
            default: ;
         endcase
      end else if (r < 68) begin
         kind = uart_rb_pkg::KIND_WRITE;
         case (s)
            0, 1: off = uart_rb_pkg::OFF_MODE;
            2, 3, 4: begin
               off = uart_rb_pkg::OFF_CMD;
               wd = random_cmd();
            end
            5, 6: off = uart_rb_pkg::OFF_FIFO;
            7: off = uart_rb_pkg::OFF_INT;
            default: ;
         endcase
      end else if (r < 90) begin
         kind = uart_rb_pkg::KIND_RXBYTE;
      end else begin
         kind = uart_rb_pkg::KIND_BREAK;
      end
      send_item(kind, off, wd, 8'($urandom_range(255)));
   endtask

   // mostly random register traffic, with bursts of line bytes then pops
   task automatic run_random(input int count);
      int n, burst;
      n = 0;
      while (n < count) begin
         if ($urandom_range(11) == 0) begin
            burst = $urandom_range(1, 5);
            repeat (burst)
               send_item(uart_rb_pkg::KIND_RXBYTE, 6'($urandom_range(63)),
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            repeat (burst)
               send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_FIFO,
                         8'($urandom_range(255)), 8'($urandom_range(255)));
            n += 2 * burst;
         end else begin
            send_random_item();
            n++;
         end
      end
   endtask

   // wait until every expected item has come back, plus a little slack
   task automatic drain_items();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   // apb write: setup phase, access phase, then back to idle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   // upper bits are noise, only the low byte counts
   task automatic set_baud(input logic [7:0] hi, input logic [7:0] lo);
      csr_write({uart_rb_pkg::CSR_BAUD_HI, 2'b00}, {24'($urandom()), hi});
      csr_write({uart_rb_pkg::CSR_BAUD_LO, 2'b00}, {24'($urandom()), lo});
   endtask

   initial begin
      int p;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_baud(8'hff, 8'h00);

      // directed: register map edges, both baud bytes, empty fifo read
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_BAUD_HI, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_BAUD_LO, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_STATUS, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_FIFO, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, OFF_LAST, 8'hff, 8'hff);
      // mode pointer: first write hits mode 0 (rx irq on full), then mode 1
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_MODE, 8'h40, 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_MODE, 8'hff, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_MODE, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(uart_rb_pkg::MISC_PTR_RESET, EN_NONE, EN_NONE), 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_MODE, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_INT, 8'hff, 8'h00);
      // byte arrives with the receiver still off
      send_item(uart_rb_pkg::KIND_RXBYTE, uart_rb_pkg::OFF_MODE, 8'h00, 8'hff);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(MISC_NONE, uart_rb_pkg::EN_CMD_ENABLE, uart_rb_pkg::EN_CMD_ENABLE),
                8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_FIFO, 8'h00, 8'h00);
      // fill the fifo, then a break overwrites the newest entry
      send_item(uart_rb_pkg::KIND_RXBYTE, uart_rb_pkg::OFF_MODE, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_RXBYTE, uart_rb_pkg::OFF_MODE, 8'h00, 8'ha5);
      send_item(uart_rb_pkg::KIND_RXBYTE, uart_rb_pkg::OFF_MODE, 8'h00, 8'h5a);
      send_item(uart_rb_pkg::KIND_BREAK, OFF_LAST, 8'hff, 8'hff);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_INT, 8'h00, 8'h00);
      send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_FIFO, 8'h00, 8'h00);
      // clear delta-break and stop the transmitter, then leave a byte pending
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(uart_rb_pkg::MISC_CLR_DB, uart_rb_pkg::EN_CMD_DISABLE, EN_NONE),
                8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_FIFO, 8'hff, 8'h00);
      // transmitter reset drops the pending byte, so enabling sends nothing
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(uart_rb_pkg::MISC_TX_RESET, EN_NONE, EN_NONE), 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(MISC_NONE, uart_rb_pkg::EN_CMD_ENABLE, EN_NONE), 8'h00);
      // reserved codes in every field
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(MISC_RSVD, EN_RSVD, EN_RSVD), 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, uart_rb_pkg::OFF_CMD,
                cmd_byte(uart_rb_pkg::MISC_RX_RESET, EN_NONE, EN_NONE), 8'h00);
      send_item(uart_rb_pkg::KIND_WRITE, OFF_UNUSED, 8'hff, 8'h00);

      // random stretches, one per traffic shape, baud changed while idle
      for (p = 0; p < 5; p++) begin
         drain_items();
         phase <= phase_type'(p);
         case (p)
            0: set_baud(8'h00, 8'hff);
            1: set_baud(8'($urandom_range(255)), 8'($urandom_range(255)));
            2: set_baud(8'hff, 8'hff);
            3: set_baud(8'($urandom_range(255)), 8'($urandom_range(255)));
            default: set_baud(8'h00, 8'h00);
         endcase
         send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_BAUD_HI, 8'h00, 8'h00);
         send_item(uart_rb_pkg::KIND_READ, uart_rb_pkg::OFF_BAUD_LO, 8'h00, 8'h00);
         run_random(183);
      end

      // open the result side and let everything come home
      phase <= PH_FREE;
      drain_items();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
